[rtl/core/raie_pkg.sv]
package raie_pkg;

    localparam int MEMORY_BYTES = 16384;

    localparam int WORD_W   = 32;
    localparam int IDX_W    = 4;
    localparam int REG_N    = 16;
    localparam int PC_W     = 14;
    localparam int LEN_W    = 3;
    localparam int ADDR_LOG = $clog2(MEMORY_BYTES);
    localparam int PC_SUM_W = ((PC_W > ADDR_LOG) ? PC_W : ADDR_LOG) + 1;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_SHORT = 3'd2;
    localparam logic [LEN_W-1:0] LEN_LONG  = 3'd4;

    localparam logic [3:0] LONG_FIRST = 4'hA;
    localparam logic [3:0] LONG_LAST  = 4'hD;
    localparam logic [3:0] ALU_LAST   = 4'h6;

    typedef enum logic [3:0] {
        OPC_HALT = 4'h0,
        OPC_ADD  = 4'h1,
        OPC_AND  = 4'h2,
        OPC_DIV  = 4'h3,
        OPC_MUL  = 4'h4,
        OPC_SUB  = 4'h5,
        OPC_OR   = 4'h6
    } opcode_t;

    localparam logic ITEM_EXEC   = 1'b0;
    localparam logic ITEM_PRESET = 1'b1;

    typedef struct packed {
        logic capture;
        logic exec;
        logic start_div;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/raie_div.sv]
module raie_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [raie_pkg::WORD_W-1:0] dividend,
    input  logic [raie_pkg::WORD_W-1:0] divisor,
    output logic                        done,
    output logic [raie_pkg::WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(raie_pkg::WORD_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [raie_pkg::WORD_W-1:0] rem_reg;
    logic [raie_pkg::WORD_W-1:0] quo_reg;
    logic [raie_pkg::WORD_W-1:0] dvs_reg;

    logic [raie_pkg::WORD_W:0]   shifted;
    logic [raie_pkg::WORD_W:0]   diff;
    logic                        qbit;
    logic [raie_pkg::WORD_W-1:0] rem_next;

    // restoring step; divisor zero naturally yields all ones
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[raie_pkg::WORD_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        qbit     = ~diff[raie_pkg::WORD_W];
        rem_next = qbit ? diff[raie_pkg::WORD_W-1:0] : shifted[raie_pkg::WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(raie_pkg::WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[raie_pkg::WORD_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

[rtl/core/raie_ctrl.sv]
module raie_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  raie_pkg::dp_status_t status,
    output logic                 in_ready,
    output raie_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_DIV,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_OP;
            end
            S_OP:
            begin
                if (status.is_div)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_div_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_done) |=> state_reg == S_COMMIT)
        else $error("divider completion not followed by commit");

endmodule

[rtl/core/raie_dpath.sv]
module raie_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  raie_pkg::ctrl_cmd_t           cmd,
    input  logic                          in_op,
    input  logic [raie_pkg::S_DATA_W-1:0] in_data,
    input  logic                          out_ready,
    output raie_pkg::dp_status_t          status,
    output logic                          out_valid,
    output logic [raie_pkg::M_DATA_W-1:0] out_data
);

    // register file: 16 entries, valid bits give the reset value of zero
    logic [raie_pkg::WORD_W-1:0] rf_mem [raie_pkg::REG_N];
    logic [raie_pkg::REG_N-1:0]  rf_valid_reg;
    logic [raie_pkg::WORD_W-1:0] rs1_reg;
    logic [raie_pkg::WORD_W-1:0] rs2_reg;

    logic                        op_reg;
    logic [7:0]                  b0_reg;
    logic [7:0]                  b1_reg;
    logic [raie_pkg::IDX_W-1:0]  lidx_reg;
    logic [raie_pkg::WORD_W-1:0] lval_reg;

    logic [raie_pkg::WORD_W-1:0] result_reg;
    logic [raie_pkg::PC_W-1:0]   pc_reg;
    logic                        halt_reg;
    logic                        out_valid_reg;
    logic [raie_pkg::M_DATA_W-1:0] out_data_reg;

    logic [raie_pkg::IDX_W-1:0]  rs1_addr;
    logic [raie_pkg::IDX_W-1:0]  rs2_addr;
    logic [3:0]                  opcode;
    logic                        is_alu;
    logic                        div_done;
    logic [raie_pkg::WORD_W-1:0] div_q;
    logic [2*raie_pkg::WORD_W-1:0] product;
    logic [raie_pkg::WORD_W-1:0] alu_out;

    logic                        we_next;
    logic [raie_pkg::IDX_W-1:0]  widx_next;
    logic [raie_pkg::WORD_W-1:0] wval_next;
    logic [raie_pkg::LEN_W-1:0]  len_next;
    logic                        halt_next;
    logic [raie_pkg::PC_SUM_W-1:0] pc_sum;
    logic [raie_pkg::PC_SUM_W-1:0] pc_wrap;
    logic [raie_pkg::PC_W-1:0]   pc_next;

    assign rs1_addr = in_data[3:0];
    assign rs2_addr = in_data[15:12];
    assign opcode   = b0_reg[7:4];
    assign is_alu   = (opcode != raie_pkg::OPC_HALT) && (opcode <= raie_pkg::ALU_LAST);

    assign status.is_div   = (op_reg == raie_pkg::ITEM_EXEC) && !halt_reg
                             && (opcode == raie_pkg::OPC_DIV);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    raie_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (rs1_reg),
        .divisor  (rs2_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign product = rs1_reg * rs2_reg;

    always_comb
    begin
        case (opcode)
            raie_pkg::OPC_ADD: alu_out = rs1_reg + rs2_reg;
            raie_pkg::OPC_AND: alu_out = rs1_reg & rs2_reg;
            raie_pkg::OPC_MUL: alu_out = product[raie_pkg::WORD_W-1:0];
            raie_pkg::OPC_SUB: alu_out = rs1_reg - rs2_reg;
            raie_pkg::OPC_OR:  alu_out = rs1_reg | rs2_reg;
            default:           alu_out = rs1_reg | rs2_reg;
        endcase
    end

    always_comb
    begin
        we_next   = 1'b0;
        widx_next = '0;
        wval_next = '0;
        len_next  = raie_pkg::LEN_NONE;
        halt_next = halt_reg;
        if (op_reg == raie_pkg::ITEM_PRESET)
        begin
            we_next   = 1'b1;
            widx_next = lidx_reg;
            wval_next = lval_reg;
        end
        else if (!halt_reg)
        begin
            len_next = ((opcode >= raie_pkg::LONG_FIRST) && (opcode <= raie_pkg::LONG_LAST))
                       ? raie_pkg::LEN_LONG : raie_pkg::LEN_SHORT;
            if (opcode == raie_pkg::OPC_HALT)
                halt_next = 1'b1;
            else if (is_alu)
            begin
                we_next   = 1'b1;
                widx_next = b1_reg[3:0];
                wval_next = result_reg;
            end
        end
        pc_sum  = raie_pkg::PC_SUM_W'(pc_reg) + raie_pkg::PC_SUM_W'(len_next);
        pc_wrap = (pc_sum >= raie_pkg::PC_SUM_W'(raie_pkg::MEMORY_BYTES))
                  ? pc_sum - raie_pkg::PC_SUM_W'(raie_pkg::MEMORY_BYTES) : pc_sum;
        pc_next = pc_wrap[raie_pkg::PC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                if (we_next)
                    rf_valid_reg[widx_next] <= 1'b1;
                pc_reg        <= pc_next;
                halt_reg      <= halt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            b0_reg   <= in_data[7:0];
            b1_reg   <= in_data[15:8];
            lidx_reg <= in_data[19:16];
            lval_reg <= in_data[51:20];
            rs1_reg  <= rf_valid_reg[rs1_addr] ? rf_mem[rs1_addr] : '0;
            rs2_reg  <= rf_valid_reg[rs2_addr] ? rf_mem[rs2_addr] : '0;
        end
        if (cmd.exec)
            result_reg <= alu_out;
        else if (div_done)
            result_reg <= div_q;
        if (cmd.commit)
        begin
            if (we_next)
                rf_mem[widx_next] <= wval_next;
            out_data_reg <= {1'b0, pc_next, len_next, halt_next, wval_next, widx_next, we_next};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transaction completed");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

endmodule

[rtl/core/register_alu_instruction_executor.sv]
// Executes one instruction or register preset per input transaction against a
// 16 x 32-bit register file, a 14-bit program counter and a halt flag, and
// returns exactly one result transaction per input. A transaction is taken only
// while the block is idle; add, and, multiply, subtract, or, preset, halt and
// PC-only instructions go from capture through execute to commit, and unsigned
// divide waits in between for the radix-2 iterative divider that resolves one
// quotient bit per cycle. A pending result sits in an output register, so the
// next transaction is accepted while it waits to be taken. The register file
// reads as zero after reset without a clearing pass.
module register_alu_instruction_executor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] first_byte, [15:8] second_byte, [19:16] load_index,
    // [51:20] load_value, [55:52] zero
    input  logic [raie_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] op
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] write_enable, [4:1] write_index, [36:5] write_value, [37] halted,
    // [40:38] instr_length, [54:41] next_pc, [55] zero
    output logic [raie_pkg::M_DATA_W-1:0] m_axis_tdata
);

    raie_pkg::ctrl_cmd_t  cmd;
    raie_pkg::dp_status_t status;

    raie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    raie_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

[bench/register_alu_instruction_executor_checker.sv]
module register_alu_instruction_executor_checker
    import raie_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    output int                  errors,
    output int                  pending,
    output int                  results,
    output int                  div_zero,
    output int                  pc_wraps,
    output int                  ignored
);

    typedef struct {
        logic             we;
        logic [IDX_W-1:0] widx;
        logic [WORD_W-1:0] wval;
        logic             halted;
        logic [LEN_W-1:0] len;
        logic [PC_W-1:0]  pc;
    } retire_t;

    retire_t           retire_q[$];
    logic [WORD_W-1:0] reg_file [REG_N];
    logic [PC_W-1:0]   pc;
    logic              halt_flag;

    retire_t           want;
    retire_t           seen;
    logic [3:0]        opc;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [WORD_W-1:0] src_a;
    logic [WORD_W-1:0] src_b;
    logic [WORD_W-1:0] alu_out;
    int                pc_sum;
    int                err_cnt;
    int                result_cnt;
    int                div_zero_cnt;
    int                wrap_cnt;
    int                ignored_cnt;

    function automatic void compare_field(string name, logic [WORD_W-1:0] want_v,
                                          logic [WORD_W-1:0] seen_v);
        if (seen_v !== want_v)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want_v, seen_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_N; i++)
                reg_file[i] = '0;
            pc           = '0;
            halt_flag    = 1'b0;
            retire_q.delete();
            err_cnt      = 0;
            result_cnt   = 0;
            div_zero_cnt = 0;
            wrap_cnt     = 0;
            ignored_cnt  = 0;
            errors       <= 0;
            pending      <= 0;
            results      <= 0;
            div_zero     <= 0;
            pc_wraps     <= 0;
            ignored      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want  = '{default: '0};
                byte0 = s_axis_tdata[7:0];
                byte1 = s_axis_tdata[15:8];
                if (s_axis_tuser == ITEM_PRESET)
                begin
                    reg_file[s_axis_tdata[19:16]] = s_axis_tdata[51:20];
                    want.we   = 1'b1;
                    want.widx = s_axis_tdata[19:16];
                    want.wval = s_axis_tdata[51:20];
                end
                else if (halt_flag)
                    ignored_cnt++;
                else
                begin
                    opc      = byte0[7:4];
                    want.len = (opc >= LONG_FIRST && opc <= LONG_LAST) ? LEN_LONG : LEN_SHORT;
                    if (opc == OPC_HALT)
                        halt_flag = 1'b1;
                    else if (opc <= ALU_LAST)
                    begin
                        src_a = reg_file[byte0[3:0]];
                        src_b = reg_file[byte1[7:4]];
                        case (opcode_t'(opc))
                            OPC_ADD: alu_out = src_a + src_b;
                            OPC_AND: alu_out = src_a & src_b;
                            OPC_DIV:
                            begin
                                if (src_b == '0)
                                begin
                                    alu_out = '1;
                                    div_zero_cnt++;
                                end
                                else
                                    alu_out = src_a / src_b;
                            end
                            OPC_MUL: alu_out = src_a * src_b;
                            OPC_SUB: alu_out = src_a - src_b;
                            default: alu_out = src_a | src_b;
                        endcase
                        reg_file[byte1[3:0]] = alu_out;
                        want.we   = 1'b1;
                        want.widx = byte1[3:0];
                        want.wval = alu_out;
                    end
                    pc_sum = (int'(pc) + int'(want.len)) % MEMORY_BYTES;
                    if (pc_sum < int'(pc))
                        wrap_cnt++;
                    pc = pc_sum[PC_W-1:0];
                end
                want.halted = halt_flag;
                want.pc     = pc;
                retire_q.push_back(want);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                result_cnt++;
                seen.we     = m_axis_tdata[0];
                seen.widx   = m_axis_tdata[4:1];
                seen.wval   = m_axis_tdata[36:5];
                seen.halted = m_axis_tdata[37];
                seen.len    = m_axis_tdata[40:38];
                seen.pc     = m_axis_tdata[54:41];
                if (retire_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = retire_q.pop_front();
                    compare_field("write_enable", WORD_W'(want.we), WORD_W'(seen.we));
                    compare_field("write_index", WORD_W'(want.widx), WORD_W'(seen.widx));
                    compare_field("write_value", want.wval, seen.wval);
                    compare_field("halted", WORD_W'(want.halted), WORD_W'(seen.halted));
                    compare_field("instr_length", WORD_W'(want.len), WORD_W'(seen.len));
                    compare_field("next_pc", WORD_W'(want.pc), WORD_W'(seen.pc));
                end
            end

            errors   <= err_cnt;
            pending  <= retire_q.size();
            results  <= result_cnt;
            div_zero <= div_zero_cnt;
            pc_wraps <= wrap_cnt;
            ignored  <= ignored_cnt;
        end
    end

endmodule

[bench/register_alu_instruction_executor_tb.sv]
module register_alu_instruction_executor_tb;

    import raie_pkg::*;

    localparam logic [3:0] OPC_FIRST_PC_ONLY = ALU_LAST + 4'h1;
    localparam logic [3:0] OPC_LAST_PC_ONLY  = 4'hF;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_cycles       = 0;

    int errors;
    int pending;
    int results;
    int div_zero;
    int pc_wraps;
    int ignored;

    register_alu_instruction_executor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    register_alu_instruction_executor_checker exec_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .results       (results),
        .div_zero      (div_zero),
        .pc_wraps      (pc_wraps),
        .ignored       (ignored)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("register_alu_instruction_executor_tb: FAIL");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    task automatic send(input logic op, input logic [7:0] byte0, input logic [7:0] byte1,
                        input logic [IDX_W-1:0] lidx, input logic [WORD_W-1:0] lval);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, lval, lidx, byte1, byte0};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic exec(input logic [3:0] opc, input logic [3:0] rs1, input logic [3:0] rs2,
                        input logic [3:0] rd);
        send(ITEM_EXEC, {opc, rs1}, {rs2, rd}, IDX_W'($urandom), $urandom);
    endtask

    task automatic preset(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        send(ITEM_PRESET, 8'($urandom), 8'($urandom), idx, val);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            preset(IDX_W'($urandom), pick_word());
        else if (pick < 85)
            exec(4'($urandom_range(OPC_ADD, OPC_OR)), 4'($urandom), 4'($urandom),
                 4'($urandom));
        else
            exec(4'($urandom_range(OPC_FIRST_PC_ONLY, OPC_LAST_PC_ONLY)), 4'($urandom),
                 4'($urandom), 4'($urandom));
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ITEM_EXEC;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 19;
        receiver_idle_pct = 47;

        // directed: corner values, every ALU op, divide by zero, PC-only opcodes
        exec(OPC_DIV, 4'd3, 4'd4, 4'd5);
        preset(4'd1, 32'hFFFF_FFFF);
        preset(4'd2, 32'h0000_0001);
        preset(4'd3, 32'h8000_0000);
        preset(4'd4, 32'h0000_0000);
        preset(4'd15, 32'h1234_5678);
        exec(OPC_ADD, 4'd1, 4'd2, 4'd5);
        exec(OPC_AND, 4'd1, 4'd3, 4'd6);
        exec(OPC_DIV, 4'd1, 4'd2, 4'd7);
        exec(OPC_DIV, 4'd1, 4'd4, 4'd8);
        exec(OPC_DIV, 4'd3, 4'd1, 4'd9);
        exec(OPC_DIV, 4'd1, 4'd1, 4'd9);
        exec(OPC_MUL, 4'd1, 4'd1, 4'd10);
        exec(OPC_MUL, 4'd3, 4'd3, 4'd11);
        exec(OPC_SUB, 4'd4, 4'd2, 4'd12);
        exec(OPC_OR, 4'd3, 4'd2, 4'd0);
        exec(OPC_ADD, 4'd15, 4'd15, 4'd15);
        exec(OPC_FIRST_PC_ONLY, 4'd1, 4'd2, 4'd3);
        exec(LONG_FIRST, 4'd1, 4'd2, 4'd3);
        exec(LONG_LAST, 4'd15, 4'd15, 4'd15);
        exec(LONG_LAST + 4'h1, 4'd0, 4'd0, 4'd0);
        exec(OPC_LAST_PC_ONLY, 4'd15, 4'd15, 4'd15);
        preset(4'd0, 32'h0000_0000);

        repeat (400) random_item();

        sender_idle_pct   = 47;
        receiver_idle_pct = 19;
        repeat (400) random_item();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_cycles       = 300;
        repeat (400) random_item();

        repeat (10) random_item();

        // halt, then items that must be ignored, presets still taking effect
        exec(OPC_HALT, 4'd1, 4'd2, 4'd3);
        exec(OPC_ADD, 4'd1, 4'd2, 4'd3);
        exec(LONG_FIRST, 4'd0, 4'd0, 4'd0);
        preset(4'd7, 32'hDEAD_BEEF);
        exec(OPC_DIV, 4'd7, 4'd4, 4'd7);
        exec(OPC_HALT, 4'd0, 4'd0, 4'd0);
        preset(4'd15, 32'hFFFF_FFFF);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d results with %0d divides by zero and %0d program counter wraps,",
                 results, div_zero, pc_wraps);
        $display("plus %0d instructions ignored after halt,", ignored);
        $display("across three idling mixes and a long hold-off");
        if (errors == 0)
            $display("register_alu_instruction_executor_tb: PASS");
        else
            $display("register_alu_instruction_executor_tb: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/raie_pkg.sv
rtl/core/raie_div.sv
rtl/core/raie_ctrl.sv
rtl/core/raie_dpath.sv
rtl/core/register_alu_instruction_executor.sv
bench/register_alu_instruction_executor_checker.sv
bench/register_alu_instruction_executor_tb.sv
